// File: src/circular_harmonics_eval_unit_defines.svh
// Assertion macros shared by the circular harmonics evaluator modules.
// Each macro expects signals clk and rst_n in the scope where it is used.
`ifndef CIRCULAR_HARMONICS_EVAL_UNIT_DEFINES_SVH
`define CIRCULAR_HARMONICS_EVAL_UNIT_DEFINES_SVH

// The condition must never hold outside reset.
`define CHE_ASSERT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CHE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

// The consequent must hold in the same cycle as the antecedent.
`define CHE_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

// File: src/che_pkg.sv
// Package of the circular harmonics evaluator: types, constants, arithmetic helpers.
// Used by the front end, CORDIC, back end and top level; depends on nothing.
package che_pkg;

  localparam int MAX_ORDER_DEF  = 15;
  localparam int ANGLE_BITS_DEF = 32;
  localparam int CORDIC_STEPS   = 28;

  localparam logic signed [31:0] CORDIC_GAIN = 32'sd652032874;
  localparam logic signed [31:0] SCALE_INV_SQRT_2PI = 32'sd214180506;
  localparam logic signed [31:0] SCALE_INV_SQRT_PI  = 32'sd302896976;
  localparam logic signed [31:0] SCALE_ONE          = 32'sd536870912;
  localparam logic signed [31:0] SCALE_SQRT2        = 32'sd759250125;

  localparam logic [1:0] NORM_FULL = 2'd0;
  localparam logic [1:0] NORM_SEMI = 2'd1;
  localparam logic [1:0] NORM_SQRT2 = 2'd2;

  localparam logic CFG_ORDER     = 1'b0;
  localparam logic CFG_NORM_MODE = 1'b1;

  typedef struct packed {
    logic [31:0]        angle;
    logic [3:0]         ord;
    logic signed [31:0] n0;
    logic signed [31:0] nm;
  } job_t;

  typedef struct packed {
    logic signed [31:0] value;
    logic [4:0]         column;
    logic               last;
  } res_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_CENTER,
    BK_CORDIC,
    BK_SCALE,
    BK_RECUR,
    BK_EMIT_C,
    BK_EMIT_S
  } bk_state_t;

  // Arctangent of 2^-i in units of 2^-32 turn.
  function automatic logic [29:0] atan_lut(input logic [4:0] idx);
    logic [29:0] v;
    case (idx)
      5'd0:  v = 30'd536870912;
      5'd1:  v = 30'd316933406;
      5'd2:  v = 30'd167458907;
      5'd3:  v = 30'd85004756;
      5'd4:  v = 30'd42667331;
      5'd5:  v = 30'd21354465;
      5'd6:  v = 30'd10679838;
      5'd7:  v = 30'd5340245;
      5'd8:  v = 30'd2670163;
      5'd9:  v = 30'd1335087;
      5'd10: v = 30'd667544;
      5'd11: v = 30'd333772;
      5'd12: v = 30'd166886;
      5'd13: v = 30'd83443;
      5'd14: v = 30'd41722;
      5'd15: v = 30'd20861;
      5'd16: v = 30'd10430;
      5'd17: v = 30'd5215;
      5'd18: v = 30'd2608;
      5'd19: v = 30'd1304;
      5'd20: v = 30'd652;
      5'd21: v = 30'd326;
      5'd22: v = 30'd163;
      5'd23: v = 30'd81;
      5'd24: v = 30'd41;
      5'd25: v = 30'd20;
      5'd26: v = 30'd10;
      5'd27: v = 30'd5;
      default: v = 30'd0;
    endcase
    return v;
  endfunction

  function automatic logic signed [31:0] sat34(input logic signed [33:0] v);
    logic signed [31:0] r;
    if (v > 34'sd2147483647) begin
      r = 32'sh7FFFFFFF;
    end else if (v < -34'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // Add half an LSB, floor-shift by 30, saturate to 32 bits.
  function automatic logic signed [31:0] round30(input logic signed [65:0] v);
    logic signed [65:0] t;
    logic signed [35:0] s;
    logic signed [31:0] r;
    t = v + 66'sd536870912;
    s = t[65:30];
    if (s > 36'sd2147483647) begin
      r = 32'sh7FFFFFFF;
    end else if (s < -36'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = s[31:0];
    end
    return r;
  endfunction

endpackage

// File: src/che_fifo.sv
// Small register queue used between front and back and in front of the result port.
// Depends on circular_harmonics_eval_unit_defines.svh for its checks.
`include "circular_harmonics_eval_unit_defines.svh"

module che_fifo #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
  localparam logic [CW-1:0] DEPTH_C  = CW'(DEPTH);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             do_push, do_pop;

  assign full    = (count_r == DEPTH_C);
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + AW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + AW'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CW'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  `CHE_ASSERT_NEVER(a_count_range, count_r > DEPTH_C, "queue count beyond depth")
  `CHE_ASSERT_NEXT(a_push_grows, do_push && !do_pop, count_r == $past(count_r) + CW'(1), "push lost")
  `CHE_ASSERT_NEXT(a_pop_shrinks, do_pop && !do_push, count_r == $past(count_r) - CW'(1), "pop lost")

endmodule

// File: src/che_front.sv
// Front end: configuration registers, order clamp, norm lookup and job queue.
// Depends on che_pkg and che_fifo.
module che_front #(
  parameter int MAX_ORDER  = che_pkg::MAX_ORDER_DEF,
  parameter int ANGLE_BITS = che_pkg::ANGLE_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cfg_we,
  input  logic          cfg_index,
  input  logic [3:0]    cfg_wdata,
  input  logic          in_push,
  input  logic [31:0]   in_angle,
  output logic          in_full,
  input  logic          job_pop,
  output che_pkg::job_t job,
  output logic          job_valid
);

  localparam logic [31:0] ANGLE_KEEP = ~(32'hFFFFFFFF >> ANGLE_BITS);
  localparam logic [4:0]  MAX_ORD_C  = 5'(MAX_ORDER);

  logic [3:0]    order_r;
  logic [1:0]    norm_mode_r;
  che_pkg::job_t job_in;
  logic          job_empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      order_r     <= 4'd1;
      norm_mode_r <= che_pkg::NORM_FULL;
    end else if (cfg_we) begin
      case (cfg_index)
        che_pkg::CFG_ORDER:     order_r     <= cfg_wdata;
        che_pkg::CFG_NORM_MODE: norm_mode_r <= cfg_wdata[1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    job_in.angle = in_angle & ANGLE_KEEP;
    job_in.ord   = ({1'b0, order_r} > MAX_ORD_C) ? MAX_ORD_C[3:0] : order_r;
    case (norm_mode_r)
      che_pkg::NORM_SEMI: begin
        job_in.n0 = che_pkg::SCALE_ONE;
        job_in.nm = che_pkg::SCALE_ONE;
      end
      che_pkg::NORM_SQRT2: begin
        job_in.n0 = che_pkg::SCALE_ONE;
        job_in.nm = che_pkg::SCALE_SQRT2;
      end
      default: begin
        job_in.n0 = che_pkg::SCALE_INV_SQRT_2PI;
        job_in.nm = che_pkg::SCALE_INV_SQRT_PI;
      end
    endcase
  end

  che_fifo #(
    .WIDTH ($bits(che_pkg::job_t)),
    .DEPTH (2)
  ) u_job_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (in_push),
    .wdata (job_in),
    .full  (in_full),
    .pop   (job_pop),
    .rdata (job),
    .empty (job_empty)
  );

  assign job_valid = !job_empty;

endmodule

// File: src/che_cordic.sv
// Iterative CORDIC: one micro-rotation per cycle, 28 micro-rotations per angle.
// Depends on che_pkg.
`include "circular_harmonics_eval_unit_defines.svh"

module che_cordic (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [31:0]        angle,
  output logic               done,
  output logic signed [31:0] cos_out,
  output logic signed [31:0] sin_out
);

  localparam logic [4:0] LAST_STEP = 5'(che_pkg::CORDIC_STEPS - 1);

  logic signed [33:0] x_r, x_nxt, y_r, y_nxt, dx, dy;
  logic signed [32:0] z_r, z_nxt, at;
  logic [1:0]         quad_r;
  logic [4:0]         step_r;
  logic               busy_r, done_r;

  assign dx = y_r >>> step_r;
  assign dy = x_r >>> step_r;
  assign at = {3'b000, che_pkg::atan_lut(step_r)};

  always_comb begin
    if (!z_r[32]) begin
      x_nxt = x_r - dx;
      y_nxt = y_r + dy;
      z_nxt = z_r - at;
    end else begin
      x_nxt = x_r + dx;
      y_nxt = y_r - dy;
      z_nxt = z_r + at;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (busy_r) begin
        if (step_r == LAST_STEP) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          step_r <= step_r + 5'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x_r    <= 34'(che_pkg::CORDIC_GAIN);
      y_r    <= '0;
      z_r    <= {3'b000, angle[29:0]};
      quad_r <= angle[31:30];
    end else if (busy_r) begin
      x_r <= x_nxt;
      y_r <= y_nxt;
      z_r <= z_nxt;
    end
  end

  // Fold the first-quadrant result back to the full turn.
  always_comb begin
    case (quad_r)
      2'd0: begin
        cos_out = che_pkg::sat34(x_r);
        sin_out = che_pkg::sat34(y_r);
      end
      2'd1: begin
        cos_out = che_pkg::sat34(-y_r);
        sin_out = che_pkg::sat34(x_r);
      end
      2'd2: begin
        cos_out = che_pkg::sat34(-x_r);
        sin_out = che_pkg::sat34(-y_r);
      end
      default: begin
        cos_out = che_pkg::sat34(y_r);
        sin_out = che_pkg::sat34(-x_r);
      end
    endcase
  end

  assign done = done_r;

  `CHE_ASSERT_NEVER(a_done_idle, done_r && busy_r, "done while still iterating")
  `CHE_ASSERT_NEXT(a_finish, busy_r && !start && step_r == LAST_STEP, done_r, "missed done")
  `CHE_ASSERT_NEVER(a_step_range, step_r > LAST_STEP, "step beyond last")

endmodule

// File: src/che_back.sv
// Back end: sequencer running CORDIC, scaling and the rotation recurrence with one multiplier.
// Depends on che_pkg and che_cordic.
`include "circular_harmonics_eval_unit_defines.svh"

module che_back (
  input  logic          clk,
  input  logic          rst_n,
  input  che_pkg::job_t job,
  input  logic          job_valid,
  output logic          job_pop,
  output logic          res_push,
  output che_pkg::res_t res,
  input  logic          res_full
);

  che_pkg::bk_state_t state_r, state_nxt;

  logic [2:0]         step_r;
  logic [4:0]         n_r;
  logic signed [31:0] cb_r, sb_r, cr_r, sr_r, ctmp_r;
  logic signed [63:0] prod_r, acc_r;
  logic signed [31:0] op_a, op_b;
  logic               cordic_start, cordic_done;
  logic signed [31:0] cordic_cos, cordic_sin;
  logic               n_is_last;

  assign n_is_last = (n_r == {1'b0, job.ord});

  che_cordic u_cordic (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (cordic_start),
    .angle   (job.angle),
    .done    (cordic_done),
    .cos_out (cordic_cos),
    .sin_out (cordic_sin)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      che_pkg::BK_IDLE:   if (job_valid) state_nxt = che_pkg::BK_CENTER;
      che_pkg::BK_CENTER: begin
        if (!res_full) begin
          state_nxt = (job.ord == 4'd0) ? che_pkg::BK_IDLE : che_pkg::BK_CORDIC;
        end
      end
      che_pkg::BK_CORDIC: if (cordic_done) state_nxt = che_pkg::BK_SCALE;
      che_pkg::BK_SCALE:  if (step_r == 3'd2) state_nxt = che_pkg::BK_EMIT_C;
      che_pkg::BK_RECUR:  if (step_r == 3'd4) state_nxt = che_pkg::BK_EMIT_C;
      che_pkg::BK_EMIT_C: if (!res_full) state_nxt = che_pkg::BK_EMIT_S;
      che_pkg::BK_EMIT_S: begin
        if (!res_full) begin
          state_nxt = n_is_last ? che_pkg::BK_IDLE : che_pkg::BK_RECUR;
        end
      end
      default: state_nxt = che_pkg::BK_IDLE;
    endcase
  end

  always_comb begin
    res_push     = 1'b0;
    job_pop      = 1'b0;
    cordic_start = 1'b0;
    res.value    = cr_r;
    res.column   = 5'({1'b0, job.ord} + n_r);
    res.last     = 1'b0;
    op_a         = cb_r;
    op_b         = cr_r;
    case (state_r)
      che_pkg::BK_CENTER: begin
        res.value    = job.n0;
        res.column   = {1'b0, job.ord};
        res.last     = (job.ord == 4'd0);
        res_push     = !res_full;
        job_pop      = !res_full && (job.ord == 4'd0);
        cordic_start = !res_full && (job.ord != 4'd0);
      end
      che_pkg::BK_SCALE: begin
        op_a = (step_r == 3'd0) ? cb_r : sb_r;
        op_b = job.nm;
      end
      che_pkg::BK_RECUR: begin
        case (step_r)
          3'd1: begin op_a = sb_r; op_b = sr_r; end
          3'd2: begin op_a = sb_r; op_b = cr_r; end
          3'd3: begin op_a = cb_r; op_b = sr_r; end
          default: begin op_a = cb_r; op_b = cr_r; end
        endcase
      end
      che_pkg::BK_EMIT_C: begin
        res_push = !res_full;
      end
      che_pkg::BK_EMIT_S: begin
        res.value  = sr_r;
        res.column = 5'({1'b0, job.ord} - n_r);
        res.last   = n_is_last;
        res_push   = !res_full;
        job_pop    = !res_full && n_is_last;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= che_pkg::BK_IDLE;
      step_r  <= '0;
      n_r     <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_nxt != state_r) begin
        step_r <= '0;
      end else begin
        step_r <= step_r + 3'd1;
      end
      if (state_r == che_pkg::BK_CENTER) begin
        n_r <= '0;
      end else if (state_r == che_pkg::BK_SCALE && step_r == 3'd2) begin
        n_r <= 5'd1;
      end else if (state_r == che_pkg::BK_EMIT_S && !res_full && !n_is_last) begin
        n_r <= n_r + 5'd1;
      end
    end
  end

  // Recurrence: cos uses acc - prod at step 2, sin uses acc + prod at step 4.
  always_ff @(posedge clk) begin
    prod_r <= op_a * op_b;
    if (state_r == che_pkg::BK_CORDIC && cordic_done) begin
      cb_r <= cordic_cos;
      sb_r <= cordic_sin;
    end
    if (state_r == che_pkg::BK_SCALE) begin
      if (step_r == 3'd1) cr_r <= che_pkg::round30(66'(prod_r));
      if (step_r == 3'd2) sr_r <= che_pkg::round30(66'(prod_r));
    end
    if (state_r == che_pkg::BK_RECUR) begin
      case (step_r)
        3'd1, 3'd3: acc_r <= prod_r;
        3'd2: ctmp_r <= che_pkg::round30(66'(acc_r) - 66'(prod_r));
        3'd4: begin
          sr_r <= che_pkg::round30(66'(acc_r) + 66'(prod_r));
          cr_r <= ctmp_r;
        end
        default: ;
      endcase
    end
  end

  `CHE_ASSERT_SAME(a_pop_on_push, job_pop, res_push && res.last, "job retired without last word")
  `CHE_ASSERT_SAME(a_last_pop, res_push && res.last, job_pop, "last word without retiring job")
  `CHE_ASSERT_NEVER(a_n_range, (state_r == che_pkg::BK_EMIT_C) && (n_r > {1'b0, job.ord}),
    "harmonic index beyond order")
  `CHE_ASSERT_NEVER(a_done_state, cordic_done && state_r != che_pkg::BK_CORDIC,
    "CORDIC result arrived outside its wait state")

endmodule

// File: src/circular_harmonics_eval_unit.sv
// Circular harmonics evaluator top level: front end, back end sequencer, result queue.
// The center word reaches the result ports through the job queue, the sequencer's idle and
// center states and the result queue. The back end works on one angle at a time; its time per
// angle is set by the iterative CORDIC and the single shared multiplier of the recurrence.
// Two angles and two result words can be queued. Synchronous active-low reset
// clears the queues and the sequencer and sets order to 1 and norm_mode to 0.
module circular_harmonics_eval_unit #(
  parameter int MAX_ORDER  = che_pkg::MAX_ORDER_DEF,
  parameter int ANGLE_BITS = che_pkg::ANGLE_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [3:0]         cfg_wdata,
  input  logic               in_push,
  input  logic [31:0]        in_angle,
  output logic               in_full,
  input  logic               out_pop,
  output logic               out_empty,
  output logic signed [31:0] out_harmonic_value,
  output logic [4:0]         out_column,
  output logic               out_last
);

  che_pkg::job_t job;
  che_pkg::res_t res, res_head;
  logic          job_valid, job_pop, res_push, res_full;

  che_front #(
    .MAX_ORDER  (MAX_ORDER),
    .ANGLE_BITS (ANGLE_BITS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_push   (in_push),
    .in_angle  (in_angle),
    .in_full   (in_full),
    .job_pop   (job_pop),
    .job       (job),
    .job_valid (job_valid)
  );

  che_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job       (job),
    .job_valid (job_valid),
    .job_pop   (job_pop),
    .res_push  (res_push),
    .res       (res),
    .res_full  (res_full)
  );

  che_fifo #(
    .WIDTH ($bits(che_pkg::res_t)),
    .DEPTH (2)
  ) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .wdata (res),
    .full  (res_full),
    .pop   (out_pop),
    .rdata (res_head),
    .empty (out_empty)
  );

  assign out_harmonic_value = res_head.value;
  assign out_column         = res_head.column;
  assign out_last           = res_head.last;

endmodule
